>>> hdl/psbc_pkg.sv
// Shared widths, tdata layout and turn codes for the barrier check unit.
// No dependencies.
`default_nettype none

package psbc_pkg;

	localparam int COORD_BITS  = 32;
	localparam int CHANCE_BITS = 16;

	// coordinate difference and cross product widths, exact with no overflow
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;

	// input tdata: eight coordinates, pass_chance, chance_draw, zero filled to bytes
	localparam int CHANCE_LSB     = 8 * COORD_BITS;
	localparam int DRAW_LSB       = CHANCE_LSB + CHANCE_BITS + 1;
	localparam int IN_USED_BITS   = DRAW_LSB + CHANCE_BITS;
	localparam int IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef enum logic [1:0] {
		TURN_COLLINEAR = 2'd0,
		TURN_CW        = 2'd1,
		TURN_CCW       = 2'd2
	} turn_t;

endpackage

`default_nettype wire

>>> hdl/probabilistic_segment_barrier_check_unit.sv
// Probabilistic barrier check: segment intersection test of a movement step
// against a run of barriers, with a sticky blocked flag. Uses psbc_pkg.
//
// Input stream (s_axis): one transfer per barrier. tdata carries the step
// start/end points, the barrier end points, pass_chance and chance_draw;
// tlast marks the last barrier of the run.
// Output stream (m_axis): one transfer per run, sent for the tlast item;
// tdata[0] is set when any barrier of the run intersected the step and its
// draw exceeded its pass chance.
// Pipeline: input register, cross product register, then the orientation
// compares, sticky flag and output register. The result of a tlast item is
// registered there as it leaves stage 2. One item per cycle sustained: the
// four orientations use eight 33x33 multipliers in parallel, one per product.
// Non-final items never wait on the output side; a final item can.
// Reset clears all valid bits and the sticky flag; no run is in progress.
// When m_axis_tready is low the result holds and the stages behind it fill;
// s_axis_tready falls only when every stage holds an item.
`default_nettype none

module probabilistic_segment_barrier_check_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output      logic                                 s_axis_tready,
	// low to high: step_start_x, step_start_y, step_end_x, step_end_y,
	// wall_start_x, wall_start_y, wall_end_x, wall_end_y, pass_chance,
	// chance_draw, zero fill
	input  wire logic [psbc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	input  wire logic                                 s_axis_tlast,   // final_wall
	output      logic                                 m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// low to high: step_blocked, zero fill
	output      logic [psbc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
	import psbc_pkg::*;

	function automatic diff_t sub_ext(input coord_t a, input coord_t b);
		diff_t r;
		r = diff_t'(a) - diff_t'(b);
		return r;
	endfunction

	function automatic prod_t mul_ext(input diff_t a, input diff_t b);
		prod_t r;
		r = prod_t'(a) * prod_t'(b);
		return r;
	endfunction

	// orientation from the sign of lhs - rhs
	function automatic turn_t turn_of(input prod_t lhs, input prod_t rhs);
		turn_t t;
		if (lhs < rhs)
			t = TURN_CCW;
		else if (lhs == rhs)
			t = TURN_COLLINEAR;
		else
			t = TURN_CW;
		return t;
	endfunction

	// q within the bounding box of p and r
	function automatic logic in_box(input point_t p, input point_t q, input point_t r);
		logic bx, by;
		bx = (q.x <= p.x || q.x <= r.x) && (q.x >= p.x || q.x >= r.x);
		by = (q.y <= p.y || q.y <= r.y) && (q.y >= p.y || q.y >= r.y);
		return bx && by;
	endfunction

	// stage 1: input register
	logic                   v_s1;
	point_t                 a_s1, b_s1, c_s1, d_s1;
	logic [CHANCE_BITS:0]   chance_s1;
	logic [CHANCE_BITS-1:0] draw_s1;
	logic                   last_s1;

	// stage 2: cross products and side conditions
	logic        v_s2;
	prod_t       prod_s2 [8];
	logic [3:0]  box_s2;
	logic        draw_gt_s2;
	logic        last_s2;

	logic        out_valid_q;
	logic        out_bit_q;
	logic        blocked_q;

	logic        out_load_ok;
	logic        fire_s2;
	logic        en_s2;
	logic        en_s1;

	diff_t       aby, abx, dcy, dcx;
	diff_t       cbx, cby, dbx, dby, adx, ady, bdx, bdy;
	prod_t       prod_c [8];
	logic [3:0]  box_c;

	turn_t       o1, o2, o3, o4;
	logic        meet_s2;
	logic        hit_s2;

	assign out_load_ok   = !out_valid_q || m_axis_tready;
	assign fire_s2       = v_s2 && (!last_s2 || out_load_ok);
	assign en_s2         = !v_s2 || fire_s2;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// differences and products of stage 1
	always_comb begin
		aby = sub_ext(b_s1.y, a_s1.y);
		abx = sub_ext(b_s1.x, a_s1.x);
		dcy = sub_ext(d_s1.y, c_s1.y);
		dcx = sub_ext(d_s1.x, c_s1.x);
		cbx = sub_ext(c_s1.x, b_s1.x);
		cby = sub_ext(c_s1.y, b_s1.y);
		dbx = sub_ext(d_s1.x, b_s1.x);
		dby = sub_ext(d_s1.y, b_s1.y);
		adx = sub_ext(a_s1.x, d_s1.x);
		ady = sub_ext(a_s1.y, d_s1.y);
		bdx = sub_ext(b_s1.x, d_s1.x);
		bdy = sub_ext(b_s1.y, d_s1.y);

		prod_c[0] = mul_ext(aby, cbx);   // turn(a, b, c)
		prod_c[1] = mul_ext(abx, cby);
		prod_c[2] = mul_ext(aby, dbx);   // turn(a, b, d)
		prod_c[3] = mul_ext(abx, dby);
		prod_c[4] = mul_ext(dcy, adx);   // turn(c, d, a)
		prod_c[5] = mul_ext(dcx, ady);
		prod_c[6] = mul_ext(dcy, bdx);   // turn(c, d, b)
		prod_c[7] = mul_ext(dcx, bdy);

		box_c[0] = in_box(a_s1, c_s1, b_s1);
		box_c[1] = in_box(a_s1, d_s1, b_s1);
		box_c[2] = in_box(c_s1, a_s1, d_s1);
		box_c[3] = in_box(c_s1, b_s1, d_s1);
	end

	// orientations and block decision of stage 2
	always_comb begin
		o1 = turn_of(prod_s2[0], prod_s2[1]);
		o2 = turn_of(prod_s2[2], prod_s2[3]);
		o3 = turn_of(prod_s2[4], prod_s2[5]);
		o4 = turn_of(prod_s2[6], prod_s2[7]);
		meet_s2 = (o1 != o2 && o3 != o4)
			|| (o1 == TURN_COLLINEAR && box_s2[0])
			|| (o2 == TURN_COLLINEAR && box_s2[1])
			|| (o3 == TURN_COLLINEAR && box_s2[2])
			|| (o4 == TURN_COLLINEAR && box_s2[3]);
		hit_s2 = meet_s2 && draw_gt_s2;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			blocked_q   <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= s_axis_tvalid;
			if (en_s2)
				v_s2 <= v_s1;
			if (fire_s2 && last_s2)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (fire_s2)
				blocked_q <= last_s2 ? 1'b0 : (blocked_q || hit_s2);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			a_s1.x    <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
			a_s1.y    <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
			b_s1.x    <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
			b_s1.y    <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
			c_s1.x    <= s_axis_tdata[4*COORD_BITS +: COORD_BITS];
			c_s1.y    <= s_axis_tdata[5*COORD_BITS +: COORD_BITS];
			d_s1.x    <= s_axis_tdata[6*COORD_BITS +: COORD_BITS];
			d_s1.y    <= s_axis_tdata[7*COORD_BITS +: COORD_BITS];
			chance_s1 <= s_axis_tdata[CHANCE_LSB +: CHANCE_BITS + 1];
			draw_s1   <= s_axis_tdata[DRAW_LSB +: CHANCE_BITS];
			last_s1   <= s_axis_tlast;
		end
		if (en_s2 && v_s1) begin
			for (int i = 0; i < 8; i++)
				prod_s2[i] <= prod_c[i];
			box_s2     <= box_c;
			draw_gt_s2 <= {1'b0, draw_s1} > chance_s1;
			last_s2    <= last_s1;
		end
		if (fire_s2 && last_s2)
			out_bit_q <= blocked_q || hit_s2;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, out_bit_q};

	// the run flag starts clean after a final item
	a_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s2 && last_s2) |=> !blocked_q)
		else $error("sticky flag not cleared after final item");

	// input stalls only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && out_valid_q))
		else $error("input stalled with a free stage");

	// a stalled result is not overwritten by the next run
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_bit_q)))
		else $error("pending result lost");

	// a non-final item never produces a result
	a_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || m_axis_tready) && !(fire_s2 && last_s2) |=> !out_valid_q)
		else $error("result without a final item");

endmodule

`default_nettype wire
